// ===== sv/can_signal_table_decoder_top_assert.svh =====
// assertion macros for the signal table decoder
`ifndef CAN_SIGNAL_TABLE_DECODER_TOP_ASSERT_SVH
`define CAN_SIGNAL_TABLE_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cstd_pkg.sv =====
`timescale 1ns / 1ps
package cstd_pkg;

    // request function codes
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_DECODE = 2'd2;

    localparam int FRAME_BYTES = 8;
    localparam logic [63:0] Q16_ONE = 64'h0000_0000_0001_0000;
    localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [28:0]        frame_id;
        logic [63:0]        payload;
        logic [3:0]         frame_len;
        logic [2:0]         start_byte;
        logic [2:0]         byte_len;
        logic               big_endian;
        logic               is_signed_field;
        logic [7:0]         bit_mask;
        logic signed [31:0] scale_q16;
        logic signed [31:0] offset_q16;
        logic [7:0]         signal_tag;
    } t_in;

    typedef struct packed {
        logic [7:0]         out_signal;
        logic signed [63:0] value_q16;
        logic               is_value;
        logic               any_match;
        logic               last_result;
    } t_out;

    // one table entry as stored in the memory
    typedef struct packed {
        logic [28:0]        frame_id;
        logic [7:0]         signal_tag;
        logic [7:0]         bit_mask;
        logic               is_signed_field;
        logic               big_endian;
        logic [2:0]         byte_len;
        logic [2:0]         start_byte;
        logic signed [31:0] scale_q16;
        logic signed [31:0] offset_q16;
    } t_entry;

endpackage

// ===== sv/can_signal_table_decoder_top.sv =====
// CAN signal table decoder. The signal table lives in a memory of MAX_ENTRIES
// entries with one write port and one read port. A clear or append request
// gives no result. A decode request reads the table one entry per cycle while
// the output is not stalled, the memory read port being the limit, and runs
// each entry through a four-stage read / match-and-gather / multiply /
// offset-and-saturate pipeline. Every decode ends with one status result
// (last_result high). A new request is taken once the status result sits in
// the output register. Stalls on the output freeze the pipeline.
`timescale 1ns / 1ps
module can_signal_table_decoder_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cstd_pkg::t_in     i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cstd_pkg::t_out    o_out
);

    `include "can_signal_table_decoder_top_assert.svh"

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    cstd_pkg::t_state r_state, n_state;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    logic           r_matched;
    logic [28:0]    r_fid;
    logic [63:0]    r_payload;
    logic [3:0]     r_flen;

    cstd_pkg::t_entry r_mem [MAX_ENTRIES];
    cstd_pkg::t_entry r_rd;

    // pipeline stage registers
    logic               r_v1, r_v2, r_v3;
    logic signed [32:0] r_ival;
    logic signed [31:0] r_scale2;
    logic signed [31:0] r_off2;
    logic               r_use_mul;
    logic [63:0]        r_const2;
    logic [7:0]         r_tag2, r_tag3;
    logic signed [63:0] r_p3;
    logic signed [31:0] r_off3;

    logic               r_ov;
    cstd_pkg::t_out     r_out;

    logic w_accept, w_issue, w_adv, w_status_load, w_match, w_fit, w_invalid;
    logic w_busy;
    logic w_sbit;
    logic [31:0] w_raw, w_hi;
    logic [3:0] w_pos;
    logic [3:0] w_end;
    logic [2:0] w_k;
    logic [7:0] w_byte;
    logic signed [32:0] w_ival;
    logic signed [64:0] w_prod;
    logic signed [64:0] w_sum;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_adv    = !(r_v3 && r_ov && !i_out_ready);
    assign w_busy   = r_v1 || r_v2 || r_v3;
    assign w_status_load = (r_state == cstd_pkg::S_DRAIN) && !w_busy
                           && (!r_ov || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cstd_pkg::S_IDLE: begin
                if (w_accept && i_in.func == cstd_pkg::FUNC_DECODE) begin
                    n_state = cstd_pkg::S_SCAN;
                end
            end
            cstd_pkg::S_SCAN: begin
                if (r_idx >= r_count) begin
                    n_state = cstd_pkg::S_DRAIN;
                end
            end
            cstd_pkg::S_DRAIN: begin
                if (w_status_load) begin
                    n_state = cstd_pkg::S_IDLE;
                end
            end
            default: n_state = cstd_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        unique case (r_state)
            cstd_pkg::S_IDLE:  o_in_ready = 1'b1;
            cstd_pkg::S_SCAN:  w_issue = (r_idx < r_count);
            cstd_pkg::S_DRAIN: w_issue = 1'b0;
            default:           o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cstd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table count, scan index, match flag and latched frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_matched <= 1'b0;
        end else begin
            if (w_accept) begin
                unique case (i_in.func)
                    cstd_pkg::FUNC_CLEAR: r_count <= '0;
                    cstd_pkg::FUNC_APPEND: begin
                        if (r_count < CW'(MAX_ENTRIES)) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    cstd_pkg::FUNC_DECODE: begin
                        r_idx     <= '0;
                        r_matched <= 1'b0;
                    end
                    default: r_count <= r_count;
                endcase
            end else begin
                if (w_adv && w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (w_adv && r_v1 && w_match) begin
                    r_matched <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.func == cstd_pkg::FUNC_DECODE) begin
            r_fid     <= i_in.frame_id;
            r_payload <= i_in.payload;
            r_flen    <= i_in.frame_len;
        end
    end

    // table memory write port: append at the current count
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.func == cstd_pkg::FUNC_APPEND && r_count < CW'(MAX_ENTRIES)) begin
            r_mem[r_count[AW-1:0]] <= '{
                frame_id:        i_in.frame_id,
                signal_tag:      i_in.signal_tag,
                bit_mask:        i_in.bit_mask,
                is_signed_field: i_in.is_signed_field,
                big_endian:      i_in.big_endian,
                byte_len:        i_in.byte_len,
                start_byte:      i_in.start_byte,
                scale_q16:       i_in.scale_q16,
                offset_q16:      i_in.offset_q16
            };
        end
    end

    // table memory read port; writes happen only while idle, so no overlap
    always_ff @(posedge i_clk) begin
        if (w_adv && w_issue) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    // match and byte range fit
    assign w_match = (r_rd.frame_id == r_fid);
    assign w_end   = {1'b0, r_rd.start_byte} + {1'b0, r_rd.byte_len};
    assign w_fit   = (w_end <= r_flen);
    assign w_invalid = (r_rd.byte_len == 3'd0) || (r_rd.byte_len > 3'd4)
                       || (w_end > 4'(cstd_pkg::FRAME_BYTES));

    // gather up to four bytes in either order
    always_comb begin
        w_raw  = '0;
        w_pos  = '0;
        w_k    = '0;
        w_byte = '0;
        for (int i = 0; i < 4; i++) begin
            w_pos  = {1'b0, r_rd.start_byte} + 4'(i);
            w_byte = w_pos[3] ? 8'd0 : r_payload[{w_pos[2:0], 3'b000} +: 8];
            w_k    = r_rd.byte_len - 3'd1 - 3'(i);
            if (3'(i) < r_rd.byte_len) begin
                if (r_rd.big_endian) begin
                    w_raw = w_raw | (32'(w_byte) << {w_k[1:0], 3'b000});
                end else begin
                    w_raw = w_raw | (32'(w_byte) << (8 * i));
                end
            end
        end
    end

    // sign extension by field length
    always_comb begin
        unique case (r_rd.byte_len)
            3'd1: begin
                w_sbit = w_raw[7];
                w_hi   = 32'hFFFF_FF00;
            end
            3'd2: begin
                w_sbit = w_raw[15];
                w_hi   = 32'hFFFF_0000;
            end
            3'd3: begin
                w_sbit = w_raw[23];
                w_hi   = 32'hFF00_0000;
            end
            default: begin
                w_sbit = w_raw[31];
                w_hi   = 32'h0000_0000;
            end
        endcase
        w_ival = (r_rd.is_signed_field && w_sbit) ? {1'b1, w_raw | w_hi} : {1'b0, w_raw};
    end

    assign w_prod = r_ival * r_scale2;
    assign w_sum  = {r_p3[63], r_p3} + 65'(r_off3);

    // pipeline: gather, multiply, offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_issue;
            r_v2 <= r_v1 && w_match && w_fit;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ival    <= w_ival;
            r_scale2  <= r_rd.scale_q16;
            r_off2    <= r_rd.offset_q16;
            r_tag2    <= r_rd.signal_tag;
            r_use_mul <= !w_invalid && (r_rd.bit_mask == 8'd0);
            if (!w_invalid && ((w_raw[7:0] & r_rd.bit_mask) != 8'd0)) begin
                r_const2 <= cstd_pkg::Q16_ONE;
            end else begin
                r_const2 <= '0;
            end
            r_p3   <= r_use_mul ? w_prod[63:0] : r_const2;
            r_off3 <= r_use_mul ? r_off2 : 32'sd0;
            r_tag3 <= r_tag2;
        end
    end

    // output register with saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_v3 && w_adv) begin
            r_ov <= 1'b1;
        end else if (w_status_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && w_adv) begin
            r_out.out_signal <= r_tag3;
            if (w_sum[64] != w_sum[63]) begin
                r_out.value_q16 <= w_sum[64] ? cstd_pkg::VAL_MIN : cstd_pkg::VAL_MAX;
            end else begin
                r_out.value_q16 <= w_sum[63:0];
            end
            r_out.is_value    <= 1'b1;
            r_out.any_match   <= 1'b1;
            r_out.last_result <= 1'b0;
        end else if (w_status_load) begin
            r_out.out_signal  <= '0;
            r_out.value_q16   <= '0;
            r_out.is_value    <= 1'b0;
            r_out.any_match   <= r_matched;
            r_out.last_result <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // checks
    `CSTD_ASSERT_NOW(a_count_range, 1'b1, r_count <= CW'(MAX_ENTRIES), "table count out of range")
    `CSTD_ASSERT_NOW(a_idle_empty, r_state == cstd_pkg::S_IDLE, !w_busy, "busy while idle")
    `CSTD_ASSERT_NEXT(a_stall_hold, r_v3 && !w_adv, r_v3 && r_ov, "stalled value lost")
    `CSTD_ASSERT_NEXT(a_status_out, w_status_load, r_ov && r_out.last_result, "no status result")
    `CSTD_ASSERT_NEXT(a_status_idle, w_status_load, r_state == cstd_pkg::S_IDLE, "not idle")

endmodule
